>>> hw/rtl/sm3_pkg.sv
// ----------------------------------------------------------------------------
// SM3 package
// Shared constants, types and round helper functions of the SM3 block.
// ----------------------------------------------------------------------------
package sm3_pkg;

	localparam int WordW = 32;
	localparam int BlockWords = 16;
	localparam int Rounds = 64;
	localparam int QueueDepth = 4;

	localparam logic [WordW-1:0] Iv [8] = '{
		32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
		32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
	};
	localparam logic [WordW-1:0] TconstLo = 32'h79cc4519;
	localparam logic [WordW-1:0] TconstHi = 32'h7a879d8a;

	// One classified word handed from the front to the back.
	typedef struct packed {
		logic [WordW-1:0] word;
		logic             start;
		logic             block_end;
		logic             final_blk;
	} sm3_cmd_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} sm3_state_t;

	function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x,
			input logic [4:0] n);
		logic [2*WordW-1:0] d;
		d = {x, x} << n;
		return d[2*WordW-1:WordW];
	endfunction

	function automatic logic [WordW-1:0] perm0(input logic [WordW-1:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [WordW-1:0] perm1(input logic [WordW-1:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

endpackage

>>> hw/rtl/sm3_front.sv
// ----------------------------------------------------------------------------
// SM3 front end
// Accepts message words, counts position within the block and marks the
// word that completes a block.
// ----------------------------------------------------------------------------
module sm3_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       in_word,
	input  logic              in_start,
	input  logic              in_final,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output sm3_pkg::sm3_cmd_t cmd
);
	import sm3_pkg::*;

	logic [3:0] count_q;
	logic [3:0] pos;

	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;
	assign pos       = in_start ? 4'd0 : count_q;

	assign cmd.word      = in_word;
	assign cmd.start     = in_start;
	assign cmd.block_end = (pos == 4'd15);
	assign cmd.final_blk = in_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_valid && cmd_ready) begin
			count_q <= pos + 4'd1;
		end
	end

endmodule

>>> hw/rtl/sm3_queue.sv
// ----------------------------------------------------------------------------
// SM3 command queue
// Small FIFO between the front end and the compression engine.
// ----------------------------------------------------------------------------
module sm3_queue #(
	parameter int Depth = sm3_pkg::QueueDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  sm3_pkg::sm3_cmd_t wr_data,
	output logic              rd_valid,
	input  logic              rd_ready,
	output sm3_pkg::sm3_cmd_t rd_data
);
	import sm3_pkg::*;

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	sm3_cmd_t        mem_q [Depth];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;
	logic            push, pop;

	assign wr_ready = (cnt_q != AW'(0) + (AW+1)'(Depth));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + AW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + AW'(1);
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

>>> hw/rtl/sm3_engine.sv
// ----------------------------------------------------------------------------
// SM3 compression engine
// Buffers a block, runs 64 rounds with a 16-word message window, folds
// into the chaining value and emits the digest on final blocks.
// ----------------------------------------------------------------------------
module sm3_engine (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_ready,
	input  sm3_pkg::sm3_cmd_t        cmd,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [31:0]              out_word,
	output logic [2:0]               out_index,
	output logic                     out_last
);
	import sm3_pkg::*;

	sm3_state_t       state_q, state_d;
	logic [31:0]      cv_q [8];
	logic [31:0]      win_q [16];
	logic [31:0]      a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [5:0]       rnd_q;
	logic [2:0]       idx_q;
	logic             fin_q;
	logic             take;

	// Round datapath.
	logic [31:0] tj, a12, ss1, ss2, tt1, tt2, ffv, ggv, wn, wj, wpj;
	always_comb begin
		tj  = rotl((rnd_q < 6'd16) ? TconstLo : TconstHi, rnd_q[4:0]);
		a12 = rotl(a_q, 5'd12);
		ss1 = rotl(a12 + e_q + tj, 5'd7);
		ss2 = ss1 ^ a12;
		if (rnd_q < 6'd16) begin
			ffv = a_q ^ b_q ^ c_q;
			ggv = e_q ^ f_q ^ g_q;
		end else begin
			ffv = (a_q & b_q) | (a_q & c_q) | (b_q & c_q);
			ggv = (e_q & f_q) | (~e_q & g_q);
		end
		wj  = win_q[0];
		wpj = win_q[0] ^ win_q[4];
		tt1 = ffv + d_q + ss2 + wpj;
		tt2 = ggv + h_q + ss1 + wj;
		wn  = perm1(win_q[0] ^ win_q[7] ^ rotl(win_q[13], 5'd15))
			^ rotl(win_q[3], 5'd7) ^ win_q[10];
	end

	assign cmd_ready = (state_q == ST_LOAD);
	assign take      = cmd_valid && cmd_ready;
	assign out_valid = (state_q == ST_EMIT);
	assign out_word  = cv_q[idx_q];
	assign out_index = idx_q;
	assign out_last  = (idx_q == 3'd7);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:  if (take && cmd.block_end) state_d = ST_ROUND;
			ST_ROUND: if (rnd_q == 6'(Rounds - 1)) state_d = ST_FOLD;
			ST_FOLD:  state_d = fin_q ? ST_EMIT : ST_LOAD;
			ST_EMIT:  if (out_ready && idx_q == 3'd7) state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			rnd_q   <= '0;
			idx_q   <= '0;
			fin_q   <= 1'b0;
			for (int i = 0; i < 8; i++) cv_q[i] <= Iv[i];
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: begin
					if (take) begin
						if (cmd.start) begin
							for (int i = 0; i < 8; i++) cv_q[i] <= Iv[i];
						end
						fin_q <= cmd.final_blk;
						rnd_q <= '0;
						idx_q <= '0;
					end
				end
				ST_ROUND: rnd_q <= rnd_q + 6'd1;
				ST_FOLD: begin
					cv_q[0] <= cv_q[0] ^ a_q;
					cv_q[1] <= cv_q[1] ^ b_q;
					cv_q[2] <= cv_q[2] ^ c_q;
					cv_q[3] <= cv_q[3] ^ d_q;
					cv_q[4] <= cv_q[4] ^ e_q;
					cv_q[5] <= cv_q[5] ^ f_q;
					cv_q[6] <= cv_q[6] ^ g_q;
					cv_q[7] <= cv_q[7] ^ h_q;
				end
				ST_EMIT: if (out_ready) idx_q <= idx_q + 3'd1;
				default: ;
			endcase
		end
	end

	// Message window and working registers carry no reset.
	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
			win_q[15] <= cmd.word;
			if (cmd.block_end) begin
				// Start flag on the closing word means a fresh IV for this block.
				a_q <= cmd.start ? Iv[0] : cv_q[0];
				b_q <= cmd.start ? Iv[1] : cv_q[1];
				c_q <= cmd.start ? Iv[2] : cv_q[2];
				d_q <= cmd.start ? Iv[3] : cv_q[3];
				e_q <= cmd.start ? Iv[4] : cv_q[4];
				f_q <= cmd.start ? Iv[5] : cv_q[5];
				g_q <= cmd.start ? Iv[6] : cv_q[6];
				h_q <= cmd.start ? Iv[7] : cv_q[7];
			end
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
			win_q[15] <= wn;
			d_q <= c_q;
			c_q <= rotl(b_q, 5'd9);
			b_q <= a_q;
			a_q <= tt1;
			h_q <= g_q;
			g_q <= rotl(f_q, 5'd19);
			f_q <= e_q;
			e_q <= perm0(tt2);
		end
	end

endmodule

>>> hw/rtl/sm3_hash_compression.sv
// ----------------------------------------------------------------------------
// SM3 hash compression
// Streams padded message words in and digest words out.
// ----------------------------------------------------------------------------
// Usage: the s_axis channel takes one 32-bit message word per item, with
// tuser carrying the start flag (bit 0) and the final-block flag (bit 1).
// The first word of a message must carry the start flag so that the
// chaining value is loaded with the standard IV; the final flag is read
// on the sixteenth word of a block only. Words enter a front counter that
// marks the block-closing word and pass through a four-entry queue, so
// words keep flowing while the engine is busy until the queue fills.
// The engine takes one word per cycle while collecting and words are
// queued, then runs the rounds (one round per cycle in a single shared
// round unit) and the fold, taking no words meanwhile. A final block
// then offers eight digest items on m_axis, index 0 first, tlast on
// index 7, one per cycle while m_axis_tready is high; a stall there
// simply holds the current item. Reset clears all control state and
// loads the IV.
// ----------------------------------------------------------------------------
module sm3_hash_compression #(
	parameter int QueueDepth = sm3_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] message_word
	input  logic [1:0]  s_axis_tuser,   // [0] start_message, [1] final_block
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] digest_index
	output logic        m_axis_tlast    // digest_last
);
	import sm3_pkg::*;

	sm3_cmd_t    f_cmd, q_cmd;
	logic        f_valid, f_ready, q_valid, q_ready;
	logic [31:0] dword;
	logic [2:0]  didx;

	sm3_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_word(s_axis_tdata), .in_start(s_axis_tuser[0]),
		.in_final(s_axis_tuser[1]),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	sm3_queue #(.Depth(QueueDepth)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
	);

	sm3_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_word(dword), .out_index(didx), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {5'd0, didx, dword};

	// The last digest item always carries index seven.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[34:32] == 3'd7)
		else $error("tlast on a digest item other than the eighth");

	// Digest index steps by one after each taken non-last item.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast
		|=> m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)
		else $error("digest index did not advance");

	// The engine takes no word from the queue while digest items are being delivered.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !q_ready)
		else $error("engine took a word during digest output");

endmodule
